@@ rtl/eic_pkg.sv @@
// Shared types and constants for the edge interrupt controller.
`timescale 1ns / 1ps

package eic_pkg;

	typedef enum logic [2:0] {
		KIND_VIDEO_LINE = 3'd0,
		KIND_SOUND_LINE = 3'd1,
		KIND_ENABLE_WR  = 3'd2,
		KIND_SELECT_WR  = 3'd3,
		KIND_ENABLE_RD  = 3'd4,
		KIND_ACK        = 3'd5
	} eic_kind_t;

	localparam logic [7:0] VEC_VIDEO = 8'hF8;
	localparam logic [7:0] VEC_SOUND = 8'hFB;
	localparam logic [7:0] VEC_NONE  = 8'h00;

	// Positions of the two sources in the pending and enable bytes.
	localparam int unsigned SRC_VIDEO_BIT = 0;
	localparam int unsigned SRC_SOUND_BIT = 3;

	typedef struct packed {
		logic [2:0] kind;
		logic       line_level;
		logic [7:0] data;
	} eic_in_t;

	typedef struct packed {
		logic       irq_request;
		logic [7:0] read_data;
		logic [7:0] vector;
		logic       ack_error;
	} eic_out_t;

endpackage

@@ rtl/edge_interrupt_controller_core.sv @@
// Two-source edge-triggered priority interrupt controller, top level.
`timescale 1ns / 1ps

// Each request is one event: a video line level change, a sound request line
// change (active low), a full write of the enable mask, a select write that
// sets or clears one enable bit, a read of the enable mask, or an interrupt
// acknowledge. Every request yields exactly one response carrying the request
// level after that event. A request is captured into an input register and
// its response is loaded into the output register when the output side can
// advance, so a stall on out_ready can hold the response back; one request
// is taken every cycle as long as the response side keeps up. The
// only limit on throughput is the output register: while a response waits,
// at most one more request is held in the input register. An acknowledge
// serves video (vector F8h) before sound (vector FBh); an acknowledge with
// neither source pending and enabled returns vector 0 with ack_error set.
module edge_interrupt_controller_core
	import eic_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  eic_in_t  in_item,
	output logic     out_valid,
	input  logic     out_ready,
	output eic_out_t out_item
);

	logic     valid_s1;
	eic_in_t  item_s1;
	logic     advance;

	// Only two pending bits can ever be set, so only those are kept.
	logic       pend_video_q;
	logic       pend_sound_q;
	logic [7:0] enable_q;
	logic       prev_video_q;
	logic       prev_sound_q;

	logic       pend_video_d;
	logic       pend_sound_d;
	logic [7:0] enable_d;
	logic       prev_video_d;
	logic       prev_sound_d;
	eic_out_t   result_d;

	logic     out_valid_q;
	eic_out_t result_q;

	logic live_video;
	logic live_sound;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	assign live_video = pend_video_q && enable_q[SRC_VIDEO_BIT];
	assign live_sound = pend_sound_q && enable_q[SRC_SOUND_BIT];

	always_comb begin
		pend_video_d = pend_video_q;
		pend_sound_d = pend_sound_q;
		enable_d     = enable_q;
		prev_video_d = prev_video_q;
		prev_sound_d = prev_sound_q;
		result_d     = '0;

		case (item_s1.kind)
			KIND_VIDEO_LINE: begin
				if (item_s1.line_level && !prev_video_q) begin
					pend_video_d = 1'b1;
				end
				prev_video_d = item_s1.line_level;
			end
			KIND_SOUND_LINE: begin
				// The sound line is active low; track its asserted level.
				if (!item_s1.line_level && !prev_sound_q) begin
					pend_sound_d = 1'b1;
				end
				prev_sound_d = !item_s1.line_level;
			end
			KIND_ENABLE_WR: begin
				enable_d = item_s1.data;
			end
			KIND_SELECT_WR: begin
				enable_d[item_s1.data[3:1]] = item_s1.data[0];
			end
			KIND_ENABLE_RD: begin
				result_d.read_data = enable_q;
			end
			KIND_ACK: begin
				if (live_video) begin
					result_d.vector = VEC_VIDEO;
					pend_video_d    = 1'b0;
				end else if (live_sound) begin
					result_d.vector = VEC_SOUND;
					pend_sound_d    = 1'b0;
				end else begin
					result_d.vector    = VEC_NONE;
					result_d.ack_error = 1'b1;
				end
			end
			default: begin
			end
		endcase

		result_d.irq_request = (pend_video_d && enable_d[SRC_VIDEO_BIT]) ||
			(pend_sound_d && enable_d[SRC_SOUND_BIT]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_video_q <= 1'b0;
			pend_sound_q <= 1'b0;
			enable_q     <= '0;
			prev_video_q <= 1'b0;
			prev_sound_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				pend_video_q <= pend_video_d;
				pend_sound_q <= pend_sound_d;
				enable_q     <= enable_d;
				prev_video_q <= prev_video_d;
				prev_sound_q <= prev_sound_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= result_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = result_q;

	// The held response always reflects the controller state it left behind.
	a_irq_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> result_q.irq_request == (live_video || live_sound))
		else $error("irq_request does not match pending and enable state");

	a_err_no_vector: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.ack_error |-> result_q.vector == VEC_NONE)
		else $error("ack_error raised together with a vector");

	a_video_ack_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.vector == VEC_VIDEO |-> !pend_video_q)
		else $error("video acknowledge left the video source pending");

	a_sound_ack_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.vector == VEC_SOUND |-> !pend_sound_q)
		else $error("sound acknowledge left the sound source pending");

	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input refused while the input register is empty");

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the edge interrupt controller core.
`timescale 1ns / 1ps

module tb;
	import eic_pkg::*;

	// The two request kinds that the block has no meaning for.
	localparam logic [2:0] KIND_SPARE_A = 3'd6;
	localparam logic [2:0] KIND_SPARE_B = 3'd7;

	localparam int unsigned MAX_REPORTED = 10;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	eic_in_t  in_item = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	eic_out_t out_item;

	// Mirror of the controller state, advanced once per accepted request.
	logic [7:0] model_pending = '0;
	logic [7:0] model_enable = '0;
	logic       video_level_q = 1'b0;
	logic       sound_asserted_q = 1'b0;

	eic_out_t expected_responses[$];
	int unsigned mismatch_count = 0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_request = 0;
	int unsigned hold_left = 0;

	edge_interrupt_controller_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #4 clk = ~clk;

	function automatic eic_in_t make_request(logic [2:0] kind, logic level, logic [7:0] data);
		eic_in_t req;
		req.kind = kind;
		req.line_level = level;
		req.data = data;
		return req;
	endfunction

	function automatic eic_out_t predict_response(eic_in_t req);
		eic_out_t rsp;
		logic [7:0] live;
		logic [7:0] sel_bit;
		rsp = '0;
		case (req.kind)
			KIND_VIDEO_LINE: begin
				if (req.line_level && !video_level_q)
					model_pending[SRC_VIDEO_BIT] = 1'b1;
				video_level_q = req.line_level;
			end
			KIND_SOUND_LINE: begin
				// The sound line is active low; only the asserted level is tracked.
				if (!req.line_level && !sound_asserted_q)
					model_pending[SRC_SOUND_BIT] = 1'b1;
				sound_asserted_q = !req.line_level;
			end
			KIND_ENABLE_WR: model_enable = req.data;
			KIND_SELECT_WR: begin
				sel_bit = 8'd1 << req.data[3:1];
				if (req.data[0])
					model_enable = model_enable | sel_bit;
				else
					model_enable = model_enable & ~sel_bit;
			end
			KIND_ENABLE_RD: rsp.read_data = model_enable;
			KIND_ACK: begin
				live = model_pending & model_enable;
				if (live[SRC_VIDEO_BIT]) begin
					rsp.vector = VEC_VIDEO;
					model_pending[SRC_VIDEO_BIT] = 1'b0;
				end else if (live[SRC_SOUND_BIT]) begin
					rsp.vector = VEC_SOUND;
					model_pending[SRC_SOUND_BIT] = 1'b0;
				end else begin
					rsp.vector = VEC_NONE;
					rsp.ack_error = 1'b1;
				end
			end
			default: ;
		endcase
		rsp.irq_request = |(model_pending & model_enable);
		return rsp;
	endfunction

	// Offers one request, with random idle cycles ahead of it, and waits for
	// acceptance. Valid is left high so back-to-back requests need no gap.
	task automatic issue_request(eic_in_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_responses.push_back(predict_response(req));
	endtask

	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		eic_out_t exp_rsp;
		if (arst_n && out_valid && out_ready) begin
			if (expected_responses.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTED)
					$display("%0t: response with no request outstanding: ", $realtime,
						"irq=%0b rd=%02h vec=%02h err=%0b",
						out_item.irq_request, out_item.read_data,
						out_item.vector, out_item.ack_error);
			end else begin
				exp_rsp = expected_responses.pop_front();
				if (out_item.irq_request !== exp_rsp.irq_request ||
						out_item.read_data !== exp_rsp.read_data ||
						out_item.vector !== exp_rsp.vector ||
						out_item.ack_error !== exp_rsp.ack_error) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTED)
						$display("%0t: mismatch: ", $realtime,
							"expected irq=%0b rd=%02h vec=%02h err=%0b, ",
							exp_rsp.irq_request, exp_rsp.read_data,
							exp_rsp.vector, exp_rsp.ack_error,
							"got irq=%0b rd=%02h vec=%02h err=%0b",
							out_item.irq_request, out_item.read_data,
							out_item.vector, out_item.ack_error);
				end
			end
		end
	end

	task automatic test_reset_defaults();
		issue_request(make_request(KIND_ENABLE_RD, 1'b0, 8'h00));
		issue_request(make_request(KIND_ACK, 1'b1, 8'hFF));
	endtask

	task automatic test_enable_register();
		issue_request(make_request(KIND_ENABLE_WR, 1'b1, 8'hFF));
		issue_request(make_request(KIND_ENABLE_RD, 1'b1, 8'hFF));
		issue_request(make_request(KIND_ENABLE_WR, 1'b0, 8'h00));
		// Upper data bits must not affect which enable bit a select write hits.
		issue_request(make_request(KIND_SELECT_WR, 1'b0, 8'hF1));
		issue_request(make_request(KIND_SELECT_WR, 1'b0, 8'h0F));
		issue_request(make_request(KIND_SELECT_WR, 1'b0, 8'h07));
		issue_request(make_request(KIND_SELECT_WR, 1'b0, 8'hFE));
		issue_request(make_request(KIND_ENABLE_RD, 1'b0, 8'h00));
	endtask

	task automatic test_video_source();
		issue_request(make_request(KIND_VIDEO_LINE, 1'b1, 8'h00));
		issue_request(make_request(KIND_VIDEO_LINE, 1'b1, 8'h00));
		issue_request(make_request(KIND_ACK, 1'b0, 8'h00));
		issue_request(make_request(KIND_ACK, 1'b0, 8'h00));
		issue_request(make_request(KIND_VIDEO_LINE, 1'b0, 8'h00));
	endtask

	task automatic test_sound_and_priority();
		issue_request(make_request(KIND_SOUND_LINE, 1'b0, 8'h00));
		issue_request(make_request(KIND_SOUND_LINE, 1'b0, 8'h00));
		issue_request(make_request(KIND_VIDEO_LINE, 1'b1, 8'h00));
		issue_request(make_request(KIND_ACK, 1'b0, 8'h00));
		issue_request(make_request(KIND_ACK, 1'b0, 8'h00));
		issue_request(make_request(KIND_SOUND_LINE, 1'b1, 8'h00));
	endtask

	task automatic test_masked_sources();
		// Only enable bits other than the two sources are set here.
		issue_request(make_request(KIND_ENABLE_WR, 1'b0, 8'hF6));
		issue_request(make_request(KIND_VIDEO_LINE, 1'b0, 8'h00));
		issue_request(make_request(KIND_VIDEO_LINE, 1'b1, 8'h00));
		issue_request(make_request(KIND_ACK, 1'b1, 8'h00));
		issue_request(make_request(KIND_SPARE_A, 1'b1, 8'hFF));
		issue_request(make_request(KIND_SPARE_B, 1'b0, 8'hA5));
	endtask

	task automatic test_random_traffic(int unsigned count);
		int unsigned done_count;
		int unsigned pick;
		logic [2:0] kind;
		logic [7:0] data;
		done_count = 0;
		while (done_count < count) begin
			pick = $urandom_range(99);
			data = $urandom_range(255);
			if (pick < 20)
				kind = KIND_VIDEO_LINE;
			else if (pick < 40)
				kind = KIND_SOUND_LINE;
			else if (pick < 50) begin
				kind = KIND_ENABLE_WR;
				if ($urandom_range(1))
					data = data | 8'h09;
			end else if (pick < 65) begin
				kind = KIND_SELECT_WR;
				// Aim half of the select writes at the two source bits.
				if ($urandom_range(1))
					data[3:1] = $urandom_range(1) ? 3'(SRC_SOUND_BIT) : 3'(SRC_VIDEO_BIT);
			end else if (pick < 75)
				kind = KIND_ENABLE_RD;
			else if (pick < 95)
				kind = KIND_ACK;
			else
				kind = $urandom_range(1) ? KIND_SPARE_A : KIND_SPARE_B;
			issue_request(make_request(kind, 1'($urandom_range(1)), data));
			if (kind != KIND_SPARE_A && kind != KIND_SPARE_B)
				done_count++;
		end
	endtask

	task automatic test_backpressure();
		int unsigned idx;
		hold_request = 60;
		for (idx = 0; idx < 30; idx++)
			issue_request(make_request($urandom_range(1) ? KIND_ACK : KIND_VIDEO_LINE,
				1'($urandom_range(1)), 8'($urandom_range(255))));
	endtask

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 8;
		recv_idle_pct = 47;
		test_reset_defaults();
		test_enable_register();
		test_video_source();
		test_sound_and_priority();
		test_masked_sources();
		test_random_traffic(470);

		send_idle_pct = 47;
		recv_idle_pct = 8;
		test_random_traffic(470);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_random_traffic(470);

		// The last request was accepted at this edge; withdraw valid at once.
		in_valid <= 1'b0;
		while (expected_responses.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatch_count == 0 && expected_responses.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
